// ----- hdl/assert_macros.svh -----
// Assertion macros used by the queue sequencer (bpq_ctrl).
// Each use expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define BPQ_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

// Antecedent implies consequent in the same cycle.
`define BPQ_ASSERT_IMPLIES(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hdl/bpq_pkg.sv -----
// ----------------------------------------------------------------------------
// Bounded priority queue package
// Sizes, codes and types shared by the queue modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bpq_pkg;

    localparam int DEPTH     = 10;
    localparam int PRIO_BITS = 8;
    localparam int DATA_BITS = 32;
    localparam int IDX_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int COUNT_W   = $clog2(DEPTH + 1);
    localparam int ENTRY_W   = PRIO_BITS + DATA_BITS;

    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    typedef struct packed {
        logic [PRIO_BITS-1:0] prio;
        logic [DATA_BITS-1:0] value;
    } entry_t;

    typedef struct packed {
        logic                 operation;
        logic [DATA_BITS-1:0] value;
        logic [PRIO_BITS-1:0] priority_req;
    } req_t;

    typedef struct packed {
        logic                 ok;
        logic [DATA_BITS-1:0] popped_value;
        logic [COUNT_W-1:0]   entry_count;
    } res_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
        entry_t           data;
    } mem_wr_t;

    typedef struct packed {
        logic             en;
        logic [IDX_W-1:0] addr;
    } mem_rd_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH_SCAN,
        S_PUSH_PLACE,
        S_POP_HEAD,
        S_POP_SHIFT,
        S_DONE
    } state_t;

endpackage

`default_nettype wire

// ----- hdl/bpq_req_if.sv -----
// ----------------------------------------------------------------------------
// Request channel
// Valid/ready channel carrying one push or pop beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bpq_req_if
    import bpq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 operation;
    logic [DATA_BITS-1:0] value;
    logic [PRIO_BITS-1:0] priority_req;

    modport source (output valid, output operation, output value, output priority_req,
                    input ready);
    modport sink   (input valid, input operation, input value, input priority_req,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/bpq_rsp_if.sv -----
// ----------------------------------------------------------------------------
// Response channel
// Valid/ready channel carrying one result beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface bpq_rsp_if
    import bpq_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic                 ok;
    logic [DATA_BITS-1:0] popped_value;
    logic [COUNT_W-1:0]   entry_count;

    modport source (output valid, output ok, output popped_value, output entry_count,
                    input ready);
    modport sink   (input valid, input ok, input popped_value, input entry_count,
                    output ready);
endinterface

`default_nettype wire

// ----- hdl/bpq_ram.sv -----
// ----------------------------------------------------------------------------
// Entry memory
// Simple dual-port RAM, one write and one registered read per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bpq_ram #(
    parameter int WIDTH = 8,
    parameter int WORDS = 4,
    parameter int AW    = (WORDS > 1) ? $clog2(WORDS) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic             re,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ----- hdl/bpq_ctrl.sv -----
// ----------------------------------------------------------------------------
// Queue sequencer
// Walks the sorted entry memory one slot a cycle to insert or remove.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bpq_ctrl
    import bpq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire req_t    in_item,
    output logic         res_valid,
    input  wire logic    res_ready,
    output res_t         res,
    output mem_wr_t      wr,
    output mem_rd_t      rd,
    input  wire entry_t  rd_data
);

    state_t               state_reg, state_next;
    logic [DATA_BITS-1:0] value_reg, value_next;
    logic [PRIO_BITS-1:0] prio_reg, prio_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [IDX_W-1:0]     ptr_reg, ptr_next;
    logic                 res_ok_reg, res_ok_next;
    logic [DATA_BITS-1:0] res_value_reg, res_value_next;

    logic                 full;
    logic                 empty;
    logic                 last_slot;
    logic                 stop_here;
    logic [IDX_W-1:0]     tail_idx;

    assign full      = (count_reg == COUNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign tail_idx  = IDX_W'(count_reg - COUNT_W'(1));
    assign last_slot = (COUNT_W'(ptr_reg) == count_reg - COUNT_W'(1));
    assign stop_here = (rd_data.prio >= prio_reg);

    assign in_ready  = (state_reg == S_IDLE);
    assign res_valid = (state_reg == S_DONE);
    assign res.ok           = res_ok_reg;
    assign res.popped_value = res_value_reg;
    assign res.entry_count  = count_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_item.operation == OP_PUSH)
                    begin
                        if (full || empty)
                            state_next = S_DONE;
                        else
                            state_next = S_PUSH_SCAN;
                    end
                    else
                    begin
                        if (empty)
                            state_next = S_DONE;
                        else
                            state_next = S_POP_HEAD;
                    end
                end
            end
            S_PUSH_SCAN:
            begin
                if (stop_here)
                    state_next = S_DONE;
                else if (ptr_reg == '0)
                    state_next = S_PUSH_PLACE;
            end
            S_PUSH_PLACE:
            begin
                state_next = S_DONE;
            end
            S_POP_HEAD:
            begin
                if (count_reg == COUNT_W'(1))
                    state_next = S_DONE;
                else
                    state_next = S_POP_SHIFT;
            end
            S_POP_SHIFT:
            begin
                if (last_slot)
                    state_next = S_DONE;
            end
            S_DONE:
            begin
                if (res_ready)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath and memory control
    always_comb
    begin
        value_next     = value_reg;
        prio_next      = prio_reg;
        count_next     = count_reg;
        ptr_next       = ptr_reg;
        res_ok_next    = res_ok_reg;
        res_value_next = res_value_reg;
        wr             = '0;
        rd             = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    value_next     = in_item.value;
                    prio_next      = in_item.priority_req;
                    res_value_next = '0;
                    res_ok_next    = 1'b0;
                    if (in_item.operation == OP_PUSH)
                    begin
                        if (!full && empty)
                        begin
                            wr.en       = 1'b1;
                            wr.addr     = '0;
                            wr.data     = '{prio: in_item.priority_req, value: in_item.value};
                            count_next  = count_reg + COUNT_W'(1);
                            res_ok_next = 1'b1;
                        end
                        else if (!full)
                        begin
                            // start the walk from the tail
                            rd.en    = 1'b1;
                            rd.addr  = tail_idx;
                            ptr_next = tail_idx;
                        end
                    end
                    else if (!empty)
                    begin
                        rd.en    = 1'b1;
                        rd.addr  = '0;
                        ptr_next = '0;
                    end
                end
            end
            S_PUSH_SCAN:
            begin
                wr.en   = 1'b1;
                wr.addr = ptr_reg + IDX_W'(1);
                if (stop_here)
                begin
                    // drop the new entry in behind equal or higher priorities
                    wr.data     = '{prio: prio_reg, value: value_reg};
                    count_next  = count_reg + COUNT_W'(1);
                    res_ok_next = 1'b1;
                end
                else
                begin
                    // move the lower entry up one slot, fetch the next one
                    wr.data = rd_data;
                    if (ptr_reg != '0)
                    begin
                        ptr_next = ptr_reg - IDX_W'(1);
                        rd.en    = 1'b1;
                        rd.addr  = ptr_reg - IDX_W'(1);
                    end
                end
            end
            S_PUSH_PLACE:
            begin
                wr.en       = 1'b1;
                wr.addr     = '0;
                wr.data     = '{prio: prio_reg, value: value_reg};
                count_next  = count_reg + COUNT_W'(1);
                res_ok_next = 1'b1;
            end
            S_POP_HEAD:
            begin
                res_value_next = rd_data.value;
                if (count_reg == COUNT_W'(1))
                begin
                    count_next  = count_reg - COUNT_W'(1);
                    res_ok_next = 1'b1;
                end
                else
                begin
                    rd.en    = 1'b1;
                    rd.addr  = IDX_W'(1);
                    ptr_next = IDX_W'(1);
                end
            end
            S_POP_SHIFT:
            begin
                // close the gap left by the head
                wr.en   = 1'b1;
                wr.addr = ptr_reg - IDX_W'(1);
                wr.data = rd_data;
                if (last_slot)
                begin
                    count_next  = count_reg - COUNT_W'(1);
                    res_ok_next = 1'b1;
                end
                else
                begin
                    ptr_next = ptr_reg + IDX_W'(1);
                    rd.en    = 1'b1;
                    rd.addr  = ptr_reg + IDX_W'(1);
                end
            end
            S_DONE:
            begin
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg     <= value_next;
        prio_reg      <= prio_next;
        ptr_reg       <= ptr_next;
        res_ok_reg    <= res_ok_next;
        res_value_reg <= res_value_next;
    end

    `BPQ_ASSERT_ALWAYS(a_count_bound, count_reg <= COUNT_W'(DEPTH), "entry count above depth")
    `BPQ_ASSERT_IMPLIES(a_no_rw_clash, wr.en && rd.en, wr.addr != rd.addr, "read and write clash")
    `BPQ_ASSERT_IMPLIES(a_scan_has_data, state_reg == S_PUSH_SCAN || state_reg == S_POP_SHIFT,
        $past(rd.en), "walk step without a pending read")
    `BPQ_ASSERT_IMPLIES(a_count_idle, state_reg == S_DONE || state_reg == S_IDLE,
        $stable(count_reg) || $past(state_reg) != S_DONE, "count moved outside an operation")

endmodule

`default_nettype wire

// ----- hdl/bounded_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// Bounded priority queue core
// Sorted-list priority queue held in one entry memory, with a result register.
// ----------------------------------------------------------------------------
//   channel  dir  beat contents
//   req      in   operation, value, priority_req
//   rsp      out  ok, popped_value, entry_count
//
// A push into an empty or full queue goes from S_IDLE straight to S_DONE;
// other pushes walk down from the tail in S_PUSH_SCAN, and S_PUSH_PLACE writes
// the head slot if the walk reaches it. A pop of an empty queue goes straight
// to S_DONE; else S_POP_HEAD takes the head and S_POP_SHIFT closes any gap.
// The result waits in S_DONE for the output register, then S_IDLE follows.
// One entry moves per cycle through the single read port of the entry memory.
// Reset clears the sequencer state, the entry count and the response valid flag;
// the memory is not cleared. A result waits in the output register while the next request is taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bounded_priority_queue_core
    import bpq_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    bpq_req_if.sink   req,
    bpq_rsp_if.source rsp
);

    req_t    in_item;
    res_t    res;
    logic    res_valid;
    logic    res_ready;
    mem_wr_t wr;
    mem_rd_t rd;
    entry_t  rd_data;

    logic                 rsp_valid_reg, rsp_valid_next;
    logic                 ok_reg, ok_next;
    logic [DATA_BITS-1:0] popped_reg, popped_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    assign in_item.operation    = req.operation;
    assign in_item.value        = req.value;
    assign in_item.priority_req = req.priority_req;

    bpq_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .in_item   (in_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .wr        (wr),
        .rd        (rd),
        .rd_data   (rd_data)
    );

    bpq_ram #(
        .WIDTH (ENTRY_W),
        .WORDS (DEPTH)
    ) u_ram (
        .clk   (clk),
        .we    (wr.en),
        .waddr (wr.addr),
        .wdata (wr.data),
        .re    (rd.en),
        .raddr (rd.addr),
        .rdata (rd_data)
    );

    // Take a new result when the output beat is empty or leaving
    assign res_ready = !rsp_valid_reg || rsp.ready;

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        ok_next        = ok_reg;
        popped_next    = popped_reg;
        count_next     = count_reg;
        if (res_valid && res_ready)
        begin
            rsp_valid_next = 1'b1;
            ok_next        = res.ok;
            popped_next    = res.popped_value;
            count_next     = res.entry_count;
        end
        else if (rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg     <= ok_next;
        popped_reg <= popped_next;
        count_reg  <= count_next;
    end

    assign rsp.valid        = rsp_valid_reg;
    assign rsp.ok           = ok_reg;
    assign rsp.popped_value = popped_reg;
    assign rsp.entry_count  = count_reg;

endmodule

`default_nettype wire

// ----- test/bounded_priority_queue_core_tb.sv -----
// ----------------------------------------------------------------------------
// Bounded priority queue core testbench
// Drives push and pop beats through the request channel with random gaps and
// receiver stalls, predicts each result from a sorted-list model held here, and
// compares every response beat field by field in order of arrival.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import bpq_pkg::*;

class bpq_scoreboard;

    logic [DATA_BITS-1:0] slot_value [DEPTH];
    logic [PRIO_BITS-1:0] slot_prio  [DEPTH];
    int unsigned          fill;
    res_t                 expected_q [$];
    int unsigned          errors;

    function new();
        fill   = 0;
        errors = 0;
    endfunction

    function int unsigned pending();
        return expected_q.size();
    endfunction

    function void fail_msg(string what, logic [DATA_BITS-1:0] want, logic [DATA_BITS-1:0] got);
        errors++;
        $display("%0t ns: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    endfunction

    // Work out the result of one accepted request beat and queue it.
    function void note_request(logic op, logic [DATA_BITS-1:0] val,
                               logic [PRIO_BITS-1:0] prio);
        res_t        res;
        int unsigned pos;
        res = '0;
        if (op == OP_PUSH)
        begin
            if (fill < DEPTH)
            begin
                pos = 0;
                // go behind every entry of equal or higher priority
                while (pos < fill && slot_prio[pos] >= prio)
                    pos++;
                for (int k = fill; k > pos; k--)
                begin
                    slot_value[k] = slot_value[k-1];
                    slot_prio[k]  = slot_prio[k-1];
                end
                slot_value[pos] = val;
                slot_prio[pos]  = prio;
                fill++;
                res.ok = 1'b1;
            end
        end
        else if (fill > 0)
        begin
            res.ok           = 1'b1;
            res.popped_value = slot_value[0];
            for (int k = 1; k < fill; k++)
            begin
                slot_value[k-1] = slot_value[k];
                slot_prio[k-1]  = slot_prio[k];
            end
            fill--;
        end
        res.entry_count = COUNT_W'(fill);
        expected_q.push_back(res);
    endfunction

    function void check_result(logic ok, logic [DATA_BITS-1:0] popped,
                               logic [COUNT_W-1:0] cnt);
        res_t want;
        if (expected_q.size() == 0)
        begin
            errors++;
            $display("%0t ns: response beat with nothing expected: ok %0b value %0h count %0d",
                     $time, ok, popped, cnt);
            return;
        end
        want = expected_q.pop_front();
        if (ok !== want.ok)
            fail_msg("ok", DATA_BITS'(want.ok), DATA_BITS'(ok));
        if (popped !== want.popped_value)
            fail_msg("popped_value", want.popped_value, popped);
        if (cnt !== want.entry_count)
            fail_msg("entry_count", DATA_BITS'(want.entry_count), DATA_BITS'(cnt));
    endfunction

endclass

module bounded_priority_queue_core_tb;

    localparam int RANDOM_ITEMS   = 1600;
    localparam int LONG_HOLD      = 400;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 40;

    logic clk;
    logic rst_n;
    bit   source_calm;
    bit   sink_calm;
    int unsigned idle_cycles = 0;

    bpq_scoreboard sb;

    bpq_req_if req_if ();
    bpq_rsp_if rsp_if ();

    bounded_priority_queue_core DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    always
    begin
        clk = 1'b1;
        #1;
        clk = 1'b0;
        #1;
    end

    // Mostly short gaps, now and then a long one; none at all in a calm phase.
    function automatic int unsigned pick_gap(input bit calm);
        int unsigned roll;
        if (calm)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 40);
    endfunction

    task automatic send_req(input logic op, input logic [DATA_BITS-1:0] val,
                            input logic [PRIO_BITS-1:0] prio);
        int unsigned gap;
        gap = pick_gap(source_calm);
        if (gap > 0)
        begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_if.valid        <= 1'b1;
        req_if.operation    <= op;
        req_if.value        <= val;
        req_if.priority_req <= prio;
        do
            @(posedge clk);
        while (!(req_if.valid && req_if.ready));
    endtask

    task automatic push(input logic [DATA_BITS-1:0] val, input logic [PRIO_BITS-1:0] prio);
        send_req(OP_PUSH, val, prio);
    endtask

    task automatic pop();
        send_req(OP_POP, DATA_BITS'($urandom()), PRIO_BITS'($urandom_range(0, 255)));
    endtask

    task automatic run_directed();
        pop();                          // empty queue
        push(32'h0000_0000, 8'd0);
        push(32'hFFFF_FFFF, 8'd255);
        push(32'hA5A5_A5A5, 8'd5);
        push(32'h5A5A_5A5A, 8'd5);      // tie: must leave after the one above
        push(32'h1234_5678, 8'd255);    // tie at the head
        push(32'h0000_0001, 8'd128);
        push(32'h8000_0000, 8'd0);      // tie at the tail
        push(32'hDEAD_BEEF, 8'd1);
        push(32'h7FFF_FFFF, 8'd254);
        push(32'hCAFE_F00D, 8'd5);      // fills the queue
        push(32'hFFFF_FFFF, 8'd255);    // refused: full
        repeat (DEPTH) pop();
        pop();                          // empty again
    endtask

    task automatic run_random();
        int unsigned sent;
        int unsigned phase_len;
        int unsigned push_pct;
        int unsigned prio_mode;
        logic [PRIO_BITS-1:0] prio;
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            phase_len   = $urandom_range(10, 60);
            source_calm = ($urandom_range(0, 3) == 0);
            sink_calm   = ($urandom_range(0, 3) == 0);
            prio_mode   = $urandom_range(0, 2);
            case ($urandom_range(0, 3))
                0: push_pct = 25;
                1: push_pct = 50;
                2: push_pct = 75;
                default: push_pct = 92;
            endcase
            repeat (phase_len)
            begin
                case (prio_mode)
                    0: prio = PRIO_BITS'($urandom_range(0, 3));     // many ties
                    1: prio = PRIO_BITS'($urandom_range(0, 255));
                    default: prio = $urandom_range(0, 1) ? 8'(255 - $urandom_range(0, 1))
                                                         : 8'($urandom_range(0, 1));
                endcase
                if ($urandom_range(1, 100) <= push_pct)
                    push(DATA_BITS'($urandom()), prio);
                else
                    pop();
                sent++;
            end
        end
    endtask

    // Receiver: random back-pressure, with two long holds that fill the block.
    initial
    begin : receiver
        int unsigned hold;
        int unsigned beats;
        hold          = 0;
        beats         = 0;
        rsp_if.ready  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (rsp_if.valid && rsp_if.ready)
            begin
                beats++;
                if (beats == 300 || beats == 1100)
                    hold = LONG_HOLD;
                else
                    hold = pick_gap(sink_calm);
            end
            if (hold > 0)
            begin
                rsp_if.ready <= 1'b0;
                hold--;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // Note accepted beats, check results and watch for a hang.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
                sb.note_request(req_if.operation, req_if.value, req_if.priority_req);
            if (rsp_if.valid && rsp_if.ready)
                sb.check_result(rsp_if.ok, rsp_if.popped_value, rsp_if.entry_count);
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t ns: no beat for %0d cycles", $time, idle_cycles);
                $display("status: fail");
                $finish;
            end
        end
    end

    initial
    begin
        sb                  = new();
        source_calm         = 1'b0;
        sink_calm           = 1'b0;
        rst_n               = 1'b0;
        req_if.valid        = 1'b0;
        req_if.operation    = OP_PUSH;
        req_if.value        = '0;
        req_if.priority_req = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_random();
        req_if.valid <= 1'b0;

        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- bounded_priority_queue_core.f -----
+incdir+hdl
hdl/bpq_pkg.sv
hdl/bpq_req_if.sv
hdl/bpq_rsp_if.sv
hdl/bpq_ram.sv
hdl/bpq_ctrl.sv
hdl/bounded_priority_queue_core.sv
test/bounded_priority_queue_core_tb.sv
